// ===== sv/mkd_pkg.sv =====
// Shared types, constants and the key character table of the multi-tap keypad decoder.
`default_nettype none

package mkd_pkg;

  localparam int unsigned KeyW  = 4;
  localparam int unsigned CharW = 8;
  localparam int unsigned TapW  = 2;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_PRESS = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_PREVIEW = 1'b0,
    KIND_COMMIT  = 1'b1
  } kind_e;

  typedef struct packed {
    logic             pending;
    logic [KeyW-1:0]  pending_key;
    logic [TapW-1:0]  tap_position;
    logic [CharW-1:0] held_char;
  } entry_t;

  typedef struct packed {
    logic             kind;
    logic [CharW-1:0] character;
    logic             last;
  } result_t;

  localparam logic [CharW-1:0] KEY_CHARS [16][4] = '{
    '{8'h64, 8'h64, 8'h64, 8'h64}, '{8'h30, 8'h51, 8'h5a, 8'h20},
    '{8'h65, 8'h65, 8'h65, 8'h65}, '{8'h66, 8'h66, 8'h66, 8'h66},
    '{8'h37, 8'h50, 8'h52, 8'h53}, '{8'h38, 8'h54, 8'h55, 8'h56},
    '{8'h39, 8'h57, 8'h58, 8'h59}, '{8'h63, 8'h63, 8'h63, 8'h63},
    '{8'h34, 8'h47, 8'h48, 8'h49}, '{8'h35, 8'h4a, 8'h4b, 8'h4c},
    '{8'h36, 8'h4d, 8'h4e, 8'h4f}, '{8'h62, 8'h62, 8'h62, 8'h62},
    '{8'h31, 8'h31, 8'h31, 8'h31}, '{8'h32, 8'h41, 8'h42, 8'h43},
    '{8'h33, 8'h44, 8'h45, 8'h46}, '{8'h61, 8'h61, 8'h61, 8'h61}
  };

  localparam logic [KeyW-1:0] KEY_SINGLE_A = 4'd0;
  localparam logic [KeyW-1:0] KEY_SINGLE_B = 4'd2;
  localparam logic [KeyW-1:0] KEY_SINGLE_C = 4'd12;

  function automatic logic single_char_key(input logic [KeyW-1:0] k);
    return (k == KEY_SINGLE_A) || (k == KEY_SINGLE_B) || (k == KEY_SINGLE_C) ||
           (k[1:0] == 2'b11);
  endfunction

endpackage

`default_nettype wire

// ===== sv/mkd_in_if.sv =====
// Request channel carrying key presses and timeout ticks.
`default_nettype none

interface mkd_in_if
  import mkd_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [KeyW-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

`default_nettype wire

// ===== sv/mkd_out_if.sv =====
// Result channel carrying previewed and committed characters.
`default_nettype none

interface mkd_out_if
  import mkd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [CharW-1:0] character;
  logic             last;

  modport source (output valid, output kind, output character, output last, input ready);
  modport sink (input valid, input kind, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/multitap_keypad_decoder.sv =====
// Top level of the multi-tap keypad decoder: entry state, decode and result queue.
//
//   channel   dir  handshake          payload
//   in_i      in   valid/ready        cmd, key
//   out_o     out  valid/ready        kind, character, last
//   cfg       in   cfg_we_i (write)   cfg_data_i = alpha_mode
//
// A request is decoded in the cycle it is accepted; its results enter a four-entry
// result queue and can leave from the next cycle on, one per cycle while out_o is ready.
// A request is accepted whenever the queue has room for two results, so one request
// per cycle is taken while the output side keeps up; a request that yields two
// results presents them on the output one after the other.
// Reset clears the entry state, alpha mode and the queue; no clearing pass is needed.
`default_nettype none

module multitap_keypad_decoder
  import mkd_pkg::*;
#(
  parameter int unsigned WINDOW_TICKS = 51
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_data_i,
  mkd_in_if.sink     in_i,
  mkd_out_if.source  out_o
);

  localparam int unsigned WinW   = $clog2(WINDOW_TICKS + 1);
  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  logic               alpha_q;
  entry_t             entry_q, entry_d;
  logic    [WinW-1:0] window_q, window_d;
  logic    [1:0]      n_res;
  result_t            res0, res1;

  result_t            queue_q [QDepth];
  logic    [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic    [CntW-1:0] count_q;
  logic               push, pop;

  mkd_decode #(
    .WINDOW_TICKS(WINDOW_TICKS),
    .WinW        (WinW)
  ) u_decode (
    .alpha_i (alpha_q),
    .cmd_i   (in_i.cmd),
    .key_i   (in_i.key),
    .entry_i (entry_q),
    .window_i(window_q),
    .entry_o (entry_d),
    .window_o(window_d),
    .count_o (n_res),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  assign in_i.ready = (count_q <= CntW'(QDepth - 2));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= 1'b0;
      entry_q  <= '0;
      window_q <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= cfg_data_i;
      end
      if (push) begin
        entry_q  <= entry_d;
        window_q <= window_d;
      end
      wr_ptr_q <= wr_ptr_q + (push ? PtrW'(n_res) : PtrW'(0));
      rd_ptr_q <= rd_ptr_q + (pop ? PtrW'(1) : PtrW'(0));
      count_q  <= count_q + (push ? CntW'(n_res) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && (n_res != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push && (n_res == 2'd2)) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  assign out_o.valid     = (count_q != '0);
  assign out_o.kind      = queue_q[rd_ptr_q].kind;
  assign out_o.character = queue_q[rd_ptr_q].character;
  assign out_o.last      = queue_q[rd_ptr_q].last;

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QDepth))
    else $error("result queue count exceeds its depth");

  a_pending_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_q.pending |-> (window_q != '0))
    else $error("entry pending with an expired window");

  a_press_yields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (cmd_e'(in_i.cmd) == CMD_PRESS)) |-> (n_res != 2'd0))
    else $error("key press produced no result");

  a_queue_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push && !pop) |=> (count_q == $past(count_q)))
    else $error("result queue count moved without a push or pop");

endmodule

`default_nettype wire

// ===== sv/mkd_decode.sv =====
// Single-pass decode of one request into the next entry state and up to two results.
`default_nettype none

module mkd_decode
  import mkd_pkg::*;
#(
  parameter int unsigned WINDOW_TICKS = 51,
  parameter int unsigned WinW = $clog2(WINDOW_TICKS + 1)
) (
  input  wire logic            alpha_i,
  input  wire logic            cmd_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire entry_t          entry_i,
  input  wire logic [WinW-1:0] window_i,
  output entry_t               entry_o,
  output logic     [WinW-1:0]  window_o,
  output logic     [1:0]       count_o,
  output result_t              res0_o,
  output result_t              res1_o
);

  result_t          res [2];
  logic    [1:0]    n;
  logic [TapW-1:0]  tap_next;

  always_comb begin
    entry_o  = entry_i;
    window_o = window_i;
    res[0]   = '0;
    res[1]   = '0;
    n        = 2'd0;
    tap_next = entry_i.tap_position + TapW'(1);
    if (cmd_e'(cmd_i) == CMD_TICK) begin
      if (entry_i.pending) begin
        if (window_i <= WinW'(1)) begin
          window_o        = '0;
          entry_o.pending = 1'b0;
          res[0]          = '{kind: KIND_COMMIT, character: entry_i.held_char, last: 1'b0};
          n               = 2'd1;
        end else begin
          window_o = window_i - WinW'(1);
        end
      end
    end else if (!alpha_i) begin
      if (entry_i.pending) begin
        entry_o.pending = 1'b0;
        window_o        = '0;
        res[0]          = '{kind: KIND_COMMIT, character: entry_i.held_char, last: 1'b0};
        n               = 2'd1;
      end
      res[n[0]] = '{kind: KIND_COMMIT, character: KEY_CHARS[key_i][0], last: 1'b0};
      n         = n + 2'd1;
    end else if (entry_i.pending && (key_i == entry_i.pending_key)) begin
      entry_o.tap_position = tap_next;
      entry_o.held_char    = KEY_CHARS[key_i][tap_next];
      res[0] = '{kind: KIND_PREVIEW, character: KEY_CHARS[key_i][tap_next], last: 1'b0};
      n      = 2'd1;
    end else begin
      if (entry_i.pending) begin
        entry_o.pending = 1'b0;
        window_o        = '0;
        res[0]          = '{kind: KIND_COMMIT, character: entry_i.held_char, last: 1'b0};
        n               = 2'd1;
      end
      if (single_char_key(key_i)) begin
        res[n[0]] = '{kind: KIND_COMMIT, character: KEY_CHARS[key_i][0], last: 1'b0};
      end else begin
        entry_o.pending      = 1'b1;
        entry_o.pending_key  = key_i;
        entry_o.tap_position = '0;
        entry_o.held_char    = KEY_CHARS[key_i][0];
        window_o             = WinW'(WINDOW_TICKS);
        res[n[0]] = '{kind: KIND_PREVIEW, character: KEY_CHARS[key_i][0], last: 1'b0};
      end
      n = n + 2'd1;
    end
    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign count_o = n;
  assign res0_o  = res[0];
  assign res1_o  = res[1];

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the multi-tap keypad decoder with its own entry predictor.
`default_nettype none

module testbench
  import mkd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WindowTicks  = 51;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned PhaseQuota   = 600;
  localparam int unsigned HoldCycles   = 300;
  localparam logic [1:0]  LastColumn   = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;

  mkd_in_if  in_if ();
  mkd_out_if out_if ();

  multitap_keypad_decoder #(
    .WINDOW_TICKS(WindowTicks)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  logic             alpha_mode;
  logic             entry_pending;
  logic [KeyW-1:0]  entry_key;
  logic [TapW-1:0]  tap_pos;
  logic [CharW-1:0] held_char;
  int unsigned      window_left;

  result_t     expected_chars[$];
  int unsigned mismatch_count;
  int unsigned requests_taken;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_span;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : receiver
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_span > 0) begin
        out_if.ready <= 1'b0;
        hold_span--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic has_one_char(logic [KeyW-1:0] k);
    return (k == KEY_SINGLE_A) || (k == KEY_SINGLE_B) || (k == KEY_SINGLE_C) ||
           (k[1:0] == LastColumn);
  endfunction

  function automatic void predict_request(cmd_e c, logic [KeyW-1:0] k);
    result_t     res[2];
    int unsigned n;
    n = 0;
    if (c == CMD_TICK) begin
      if (entry_pending) begin
        if (window_left <= 1) begin
          window_left   = 0;
          entry_pending = 1'b0;
          res[n] = '{kind: KIND_COMMIT, character: held_char, last: 1'b0};
          n++;
        end else begin
          window_left--;
        end
      end
    end else if (!alpha_mode) begin
      if (entry_pending) begin
        entry_pending = 1'b0;
        window_left   = 0;
        res[n] = '{kind: KIND_COMMIT, character: held_char, last: 1'b0};
        n++;
      end
      res[n] = '{kind: KIND_COMMIT, character: KEY_CHARS[k][0], last: 1'b0};
      n++;
    end else if (entry_pending && k == entry_key) begin
      tap_pos   = tap_pos + 1'b1;
      held_char = KEY_CHARS[k][tap_pos];
      res[n] = '{kind: KIND_PREVIEW, character: held_char, last: 1'b0};
      n++;
    end else begin
      if (entry_pending) begin
        entry_pending = 1'b0;
        window_left   = 0;
        res[n] = '{kind: KIND_COMMIT, character: held_char, last: 1'b0};
        n++;
      end
      if (has_one_char(k)) begin
        res[n] = '{kind: KIND_COMMIT, character: KEY_CHARS[k][0], last: 1'b0};
        n++;
      end else begin
        entry_pending = 1'b1;
        entry_key     = k;
        tap_pos       = '0;
        held_char     = KEY_CHARS[k][0];
        window_left   = WindowTicks;
        res[n] = '{kind: KIND_PREVIEW, character: held_char, last: 1'b0};
        n++;
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      expected_chars.push_back(res[i]);
    end
  endfunction

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%s at %0t: expected kind=%0d char=%h last=%0d, got kind=%0d char=%h last=%0d",
               what, $time, want.kind, want.character, want.last,
               got.kind, got.character, got.last);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{kind: out_if.kind, character: out_if.character, last: out_if.last};
      if (expected_chars.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_chars.pop_front();
        if (got.kind !== want.kind || got.character !== want.character ||
            got.last !== want.last) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  task automatic send_request(cmd_e c, logic [KeyW-1:0] k);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= c;
    in_if.key   <= k;
    do @(posedge clk_i); while (!in_if.ready);
    if (c == CMD_PRESS || entry_pending) requests_taken++;
    predict_request(c, k);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    alpha_mode = mode;
  endtask

  task automatic test_numeric_entry();
    send_request(CMD_PRESS, 4'd0);
    send_request(CMD_PRESS, 4'd15);
    send_request(CMD_PRESS, 4'd1);
    send_request(CMD_PRESS, 4'd13);
    send_request(CMD_TICK, 4'd0);
  endtask

  task automatic test_single_char_keys();
    write_mode(1'b1);
    send_request(CMD_PRESS, KEY_SINGLE_A);
    send_request(CMD_PRESS, KEY_SINGLE_B);
    send_request(CMD_PRESS, KEY_SINGLE_C);
    send_request(CMD_PRESS, 4'd3);
    send_request(CMD_PRESS, 4'd7);
    send_request(CMD_PRESS, 4'd11);
    send_request(CMD_PRESS, 4'd15);
  endtask

  task automatic test_tap_cycling();
    repeat (5) send_request(CMD_PRESS, 4'd13);
    send_request(CMD_PRESS, 4'd1);
    send_request(CMD_PRESS, 4'd3);
  endtask

  task automatic test_mode_switch_pending();
    send_request(CMD_PRESS, 4'd5);
    write_mode(1'b0);
    send_request(CMD_PRESS, 4'd9);
    send_request(CMD_PRESS, 4'd8);
    write_mode(1'b1);
  endtask

  // The repeated press must not restart the window, and the count carries
  // across a mode change.
  task automatic test_window_expiry();
    send_request(CMD_PRESS, 4'd6);
    send_request(CMD_PRESS, 4'd6);
    repeat (20) send_request(CMD_TICK, 4'd6);
    send_request(CMD_PRESS, 4'd6);
    write_mode(1'b0);
    repeat (30) send_request(CMD_TICK, 4'd15);
    send_request(CMD_TICK, 4'd0);
    send_request(CMD_TICK, 4'd0);
    write_mode(1'b1);
  endtask

  task automatic tap_word_entry();
    logic [KeyW-1:0] k;
    int unsigned     taps;
    k = KeyW'($urandom_range(15));
    while (has_one_char(k)) k = KeyW'($urandom_range(15));
    taps = $urandom_range(5);
    send_request(CMD_PRESS, k);
    repeat (taps) begin
      if ($urandom_range(3) == 0) send_request(CMD_TICK, KeyW'($urandom_range(15)));
      send_request(CMD_PRESS, k);
    end
    if ($urandom_range(4) == 0) begin
      while (entry_pending) send_request(CMD_TICK, KeyW'($urandom_range(15)));
    end
  endtask

  task automatic test_random_traffic(int unsigned quota);
    int unsigned goal;
    goal = requests_taken + quota;
    while (requests_taken < goal) begin
      if ($urandom_range(9) == 0) write_mode(1'($urandom_range(1)));
      if ($urandom_range(9) < 2) begin
        repeat ($urandom_range(1, 6)) begin
          send_request(cmd_e'($urandom_range(1)), KeyW'($urandom_range(15)));
        end
      end else begin
        tap_word_entry();
      end
    end
  endtask

  task automatic test_output_backpressure();
    int unsigned saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    write_mode(1'b1);
    hold_span = HoldCycles;
    repeat (40) send_request(CMD_PRESS, KeyW'($urandom_range(15)));
    drain_results();
    send_idle_pct = saved_idle;
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = 1'b0;
    in_if.valid    = 1'b0;
    in_if.cmd      = CMD_TICK;
    in_if.key      = '0;
    alpha_mode     = 1'b0;
    entry_pending  = 1'b0;
    entry_key      = '0;
    tap_pos        = '0;
    held_char      = '0;
    window_left    = 0;
    mismatch_count = 0;
    requests_taken = 0;
    hold_span      = 0;
    send_idle_pct  = 18;
    recv_idle_pct  = 84;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_numeric_entry();
    test_single_char_keys();
    test_tap_cycling();
    test_mode_switch_pending();
    test_window_expiry();
    test_random_traffic(PhaseQuota);

    send_idle_pct = 84;
    recv_idle_pct = 18;
    test_output_backpressure();
    test_random_traffic(PhaseQuota);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(PhaseQuota);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
